// ----- hdl/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Types and constants shared by the crash confirmation sequencer.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CountW = 8;
    localparam int AccelW = 12;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 12;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_STILL  = 2'd2,
        PH_CANCEL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OC_NONE      = 2'd0,
        OC_FALSE     = 2'd1,
        OC_CANCELLED = 2'd2,
        OC_SOS       = 2'd3
    } outcome_t;

    localparam logic [CfgIdxW-1:0] REG_SETTLE_TICKS = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_STILL_TICKS  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CANCEL_TICKS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_STILL_LOW    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_STILL_HIGH   = 3'd4;

    localparam logic [CountW-1:0] RST_SETTLE_TICKS = 8'd30;
    localparam logic [CountW-1:0] RST_STILL_TICKS  = 8'd20;
    localparam logic [CountW-1:0] RST_CANCEL_TICKS = 8'd100;
    localparam logic [AccelW-1:0] RST_STILL_LOW    = 12'd128;
    localparam logic [AccelW-1:0] RST_STILL_HIGH   = 12'd384;

    typedef struct packed {
        logic              shock_event;
        logic              warning_event;
        logic              vital_event;
        logic [AccelW-1:0] accel_mag;
        logic              cancel_level;
    } item_t;

    typedef struct packed {
        logic       alert_level;
        logic       crash_shown;
        logic       send_warning;
        logic       send_sos;
        logic [1:0] outcome;
        logic [1:0] phase_now;
    } result_t;

    typedef struct packed {
        logic [CountW-1:0] settle_ticks;
        logic [CountW-1:0] still_ticks;
        logic [CountW-1:0] cancel_ticks;
        logic [AccelW-1:0] still_low;
        logic [AccelW-1:0] still_high;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [CountW-1:0] tick_count;
        logic              still_ok;
        logic              shock_pending;
        logic              warning_pending;
        logic              vital_pending;
    } seq_state_t;

endpackage

// ----- hdl/ccs_step.sv -----
// ----------------------------------------------------------------------------
// ccs_step
// One tick of the sequencer: next state and result for one request.
// ----------------------------------------------------------------------------
module ccs_step
    import ccs_pkg::*;
(
    input  seq_state_t cur,
    input  cfg_t       cfg,
    input  item_t      item,
    output seq_state_t nxt,
    output result_t    res
);

    logic              shock_p;
    logic              warn_p;
    logic              vital_p;
    logic [CountW-1:0] count_inc;
    logic [CountW-1:0] limit;
    logic [CountW-1:0] limit_eff;
    logic              count_done;
    logic              sample_bad;
    logic              warn_pulse;
    logic              sos_pulse;
    outcome_t          outcome;

    assign shock_p = cur.shock_pending | item.shock_event;
    assign warn_p  = cur.warning_pending | item.warning_event;
    assign vital_p = cur.vital_pending | item.vital_event;

    always_comb
    begin
        unique case (cur.phase)
            PH_SETTLE: limit = cfg.settle_ticks;
            PH_STILL:  limit = cfg.still_ticks;
            default:   limit = cfg.cancel_ticks;
        endcase
    end

    assign count_inc  = cur.tick_count + 8'd1;
    assign limit_eff  = (limit == '0) ? 8'd1 : limit;
    assign count_done = (count_inc >= limit_eff);
    assign sample_bad = (item.accel_mag > cfg.still_high) || (item.accel_mag < cfg.still_low);

    // next state
    always_comb
    begin
        nxt                 = cur;
        nxt.shock_pending   = shock_p;
        nxt.warning_pending = warn_p;
        nxt.vital_pending   = vital_p;
        unique case (cur.phase)
            PH_IDLE:
            begin
                nxt.warning_pending = 1'b0;
                if (vital_p)
                begin
                    nxt.phase      = PH_CANCEL;
                    nxt.tick_count = '0;
                    nxt.still_ok   = 1'b1;
                end
                else if (shock_p)
                begin
                    nxt.phase      = PH_SETTLE;
                    nxt.tick_count = '0;
                    nxt.still_ok   = 1'b1;
                end
            end
            PH_SETTLE:
            begin
                nxt.tick_count = count_inc;
                if (count_done)
                begin
                    nxt.phase      = PH_STILL;
                    nxt.tick_count = '0;
                    nxt.still_ok   = 1'b1;
                end
            end
            PH_STILL:
            begin
                nxt.tick_count = count_inc;
                nxt.still_ok   = cur.still_ok & ~sample_bad;
                if (count_done)
                begin
                    nxt.tick_count = '0;
                    nxt.still_ok   = 1'b1;
                    if (cur.still_ok && !sample_bad)
                    begin
                        nxt.phase = PH_CANCEL;
                    end
                    else
                    begin
                        nxt.phase         = PH_IDLE;
                        nxt.shock_pending = 1'b0;
                        nxt.vital_pending = 1'b0;
                    end
                end
            end
            PH_CANCEL:
            begin
                nxt.tick_count = count_inc;
                if (item.cancel_level || count_done)
                begin
                    nxt.phase         = PH_IDLE;
                    nxt.tick_count    = '0;
                    nxt.still_ok      = 1'b1;
                    nxt.shock_pending = 1'b0;
                    nxt.vital_pending = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        warn_pulse = 1'b0;
        sos_pulse  = 1'b0;
        outcome    = OC_NONE;
        unique case (cur.phase)
            PH_IDLE:
            begin
                warn_pulse = warn_p;
            end
            PH_SETTLE:
            begin
                outcome = OC_NONE;
            end
            PH_STILL:
            begin
                if (count_done && !(cur.still_ok && !sample_bad))
                begin
                    outcome = OC_FALSE;
                end
            end
            PH_CANCEL:
            begin
                if (item.cancel_level)
                begin
                    outcome = OC_CANCELLED;
                end
                else if (count_done)
                begin
                    outcome   = OC_SOS;
                    sos_pulse = 1'b1;
                end
            end
            default:
            begin
                outcome = OC_NONE;
            end
        endcase
    end

    assign res.alert_level  = (nxt.phase == PH_CANCEL);
    assign res.crash_shown  = (nxt.phase == PH_CANCEL);
    assign res.send_warning = warn_pulse;
    assign res.send_sos     = sos_pulse;
    assign res.outcome      = outcome;
    assign res.phase_now    = nxt.phase;

endmodule

// ----- hdl/crash_confirmation_sequencer.sv -----
// ----------------------------------------------------------------------------
// crash_confirmation_sequencer
// Tick-driven crash confirmation: settle, stillness check, cancel window.
// ----------------------------------------------------------------------------
//   channel   signals                             dir   notes
//   item      item_valid/item_ready, item         in    one request per tick
//   result    result_valid/result_ready, result   out   one result per request
//   cfg       cfg_we, cfg_index, cfg_data         in    write only, no wait
//
// One request per cycle unless result_ready holds it back; its result is registered and shows in the next cycle.
// The state update and result come from a single compare-and-count stage.
// A new request is taken while the result register is empty or being drained.
// Reset puts the sequencer idle with default register values; no clearing pass.
// ----------------------------------------------------------------------------
module crash_confirmation_sequencer
    import ccs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                result_valid,
    input  logic                result_ready,
    output result_t             result,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       valid_reg;
    logic       take;

    assign item_ready   = !valid_reg || result_ready;
    assign take         = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    ccs_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item),
        .nxt  (state_next),
        .res  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks <= RST_SETTLE_TICKS;
            cfg_reg.still_ticks  <= RST_STILL_TICKS;
            cfg_reg.cancel_ticks <= RST_CANCEL_TICKS;
            cfg_reg.still_low    <= RST_STILL_LOW;
            cfg_reg.still_high   <= RST_STILL_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data[CountW-1:0];
                REG_STILL_TICKS:  cfg_reg.still_ticks  <= cfg_data[CountW-1:0];
                REG_CANCEL_TICKS: cfg_reg.cancel_ticks <= cfg_data[CountW-1:0];
                REG_STILL_LOW:    cfg_reg.still_low    <= cfg_data[AccelW-1:0];
                REG_STILL_HIGH:   cfg_reg.still_high   <= cfg_data[AccelW-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_IDLE;
            state_reg.tick_count      <= '0;
            state_reg.still_ok        <= 1'b1;
            state_reg.shock_pending   <= 1'b0;
            state_reg.warning_pending <= 1'b0;
            state_reg.vital_pending   <= 1'b0;
            valid_reg                 <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_alert_phase: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (result_reg.alert_level == (result_reg.phase_now == PH_CANCEL)))
        else $error("alert level disagrees with phase");

    a_sos_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.send_sos) |-> (result_reg.outcome == OC_SOS))
        else $error("sos pulse without sos outcome");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.outcome != OC_NONE) |-> (result_reg.phase_now == PH_IDLE))
        else $error("sequence end without return to idle");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) |-> (state_reg.tick_count == '0 && state_reg.still_ok))
        else $error("idle with stale counter");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(state_reg))
        else $error("state moved without a request");
`endif

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for crash_confirmation_sequencer. A table of directed
// ticks covers event latching, warning pulses, vital and shock sequences,
// count registers of zero, in-band and crossed stillness bounds, and a cancel
// on the last window tick. Random phases follow, mostly well-formed shock and
// vital sequences under several register settings. Every result is checked
// field by field against a tick-level predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import ccs_pkg::*;

    localparam int StallLimit = 200;
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
        item_t               req;
        logic                typed;
        result_t             status;
    } plan_row_t;

    typedef struct packed {
        result_t predicted;
        logic    typed;
        result_t status;
    } awaited_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_ready;
    item_t               item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // typed expectation that rides along with the request on the table rows
    logic                row_typed = 1'b0;
    result_t             row_status = '0;

    cfg_t                regs;
    seq_state_t          seq;
    awaited_t            awaited_status[$];
    plan_row_t           plan[$];
    bit                  idling = 1'b1;
    int unsigned         quiet_cycles = 0;
    int unsigned         errors = 0;
    int unsigned         ticks_sent = 0;
    int unsigned         results_seen = 0;
    int unsigned         cfg_writes = 0;
    int unsigned         n_warn = 0;
    int unsigned         n_false = 0;
    int unsigned         n_cancel = 0;
    int unsigned         n_sos = 0;

    crash_confirmation_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
        case (idx)
            REG_SETTLE_TICKS: regs.settle_ticks = data[CountW-1:0];
            REG_STILL_TICKS:  regs.still_ticks  = data[CountW-1:0];
            REG_CANCEL_TICKS: regs.cancel_ticks = data[CountW-1:0];
            REG_STILL_LOW:    regs.still_low    = data[AccelW-1:0];
            REG_STILL_HIGH:   regs.still_high   = data[AccelW-1:0];
            default: ;
        endcase
    endfunction

    function automatic void enter_phase(input phase_t p);
        seq.phase = p;
        seq.tick_count = '0;
        seq.still_ok = 1'b1;
    endfunction

    function automatic void close_sequence();
        enter_phase(PH_IDLE);
        seq.shock_pending = 1'b0;
        seq.vital_pending = 1'b0;
    endfunction

    // zero limit acts as one
    function automatic logic tick_done(input logic [CountW-1:0] limit);
        logic [CountW-1:0] nxt;
        logic [CountW-1:0] lim;
        nxt = seq.tick_count + 8'd1;
        lim = (limit == '0) ? 8'd1 : limit;
        seq.tick_count = nxt;
        return nxt >= lim;
    endfunction

    function automatic result_t advance_sequence(input item_t r);
        result_t st;
        st = '0;
        if (r.shock_event) seq.shock_pending = 1'b1;
        if (r.warning_event) seq.warning_pending = 1'b1;
        if (r.vital_event) seq.vital_pending = 1'b1;
        case (seq.phase)
            PH_IDLE:
            begin
                if (seq.warning_pending)
                begin
                    st.send_warning = 1'b1;
                    seq.warning_pending = 1'b0;
                end
                if (seq.vital_pending) enter_phase(PH_CANCEL);
                else if (seq.shock_pending) enter_phase(PH_SETTLE);
            end
            PH_SETTLE:
            begin
                if (tick_done(regs.settle_ticks)) enter_phase(PH_STILL);
            end
            PH_STILL:
            begin
                if (r.accel_mag > regs.still_high || r.accel_mag < regs.still_low)
                    seq.still_ok = 1'b0;
                if (tick_done(regs.still_ticks))
                begin
                    if (seq.still_ok)
                        enter_phase(PH_CANCEL);
                    else
                    begin
                        st.outcome = OC_FALSE;
                        close_sequence();
                    end
                end
            end
            default:
            begin
                if (r.cancel_level)
                begin
                    st.outcome = OC_CANCELLED;
                    close_sequence();
                end
                else if (tick_done(regs.cancel_ticks))
                begin
                    st.send_sos = 1'b1;
                    st.outcome = OC_SOS;
                    close_sequence();
                end
            end
        endcase
        st.alert_level = (seq.phase == PH_CANCEL);
        st.crash_shown = (seq.phase == PH_CANCEL);
        st.phase_now = seq.phase;
        return st;
    endfunction

    // ---------------- checking ----------------

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic compare_status(input string src, input result_t got,
                                  input result_t want);
        if (got.alert_level !== want.alert_level)
            report({src, " alert_level"}, 16'(got.alert_level), 16'(want.alert_level));
        if (got.crash_shown !== want.crash_shown)
            report({src, " crash_shown"}, 16'(got.crash_shown), 16'(want.crash_shown));
        if (got.send_warning !== want.send_warning)
            report({src, " send_warning"}, 16'(got.send_warning), 16'(want.send_warning));
        if (got.send_sos !== want.send_sos)
            report({src, " send_sos"}, 16'(got.send_sos), 16'(want.send_sos));
        if (got.outcome !== want.outcome)
            report({src, " outcome"}, 16'(got.outcome), 16'(want.outcome));
        if (got.phase_now !== want.phase_now)
            report({src, " phase_now"}, 16'(got.phase_now), 16'(want.phase_now));
    endtask

    always @(posedge clk)
    begin
        awaited_t a;
        logic     took_req;
        logic     took_res;
        took_req = item_valid && item_ready;
        took_res = result_valid && result_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                apply_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (took_req)
            begin
                a.predicted = advance_sequence(item);
                a.typed = row_typed;
                a.status = row_status;
                awaited_status.push_back(a);
                ticks_sent++;
            end
            if (took_res)
            begin
                results_seen++;
                if (result.send_warning) n_warn++;
                case (outcome_t'(result.outcome))
                    OC_FALSE:     n_false++;
                    OC_CANCELLED: n_cancel++;
                    OC_SOS:       n_sos++;
                    default: ;
                endcase
                if (awaited_status.size() == 0)
                    report("with nothing awaited", 16'(result), 16'd0);
                else
                begin
                    a = awaited_status.pop_front();
                    compare_status("predicted", result, a.predicted);
                    if (a.typed) compare_status("table", result, a.status);
                end
            end
            if (cfg_we || took_req || took_res) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= StallLimit);
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 StallLimit, awaited_status.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------- result side ----------------

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = idling ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    // ---------------- request side ----------------

    task automatic send_req(input item_t r, input logic typed, input result_t want);
        int gap;
        gap = idling ? $urandom_range(0, 7) : 0;
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= r;
        row_typed <= typed;
        row_status <= want;
        do @(posedge clk); while (!(item_valid && item_ready));
    endtask

    // hold requests until every result is back
    task automatic quiesce();
        item_valid <= 1'b0;
        cfg_we <= 1'b0;
        do @(posedge clk); while (awaited_status.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CfgDataW-1:0] settle, still, cancel, lo, hi);
        quiesce();
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_STILL_TICKS, still);
        write_reg(REG_CANCEL_TICKS, cancel);
        write_reg(REG_STILL_LOW, lo);
        write_reg(REG_STILL_HIGH, hi);
    endtask

    // short count, sometimes with junk in the unused upper bits
    function automatic logic [CfgDataW-1:0] count_draw();
        int unsigned w;
        w = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) w += $urandom_range(1, 15) << 8;
        return w[CfgDataW-1:0];
    endfunction

    function automatic item_t pick_request();
        item_t             r;
        logic [CountW-1:0] lim;
        r.accel_mag = 12'($urandom_range(0, 4095));
        r.cancel_level = $urandom_range(0, 7) == 0;
        if ($urandom_range(0, 9) == 0)
        begin
            r.shock_event = $urandom_range(0, 1) == 1;
            r.warning_event = $urandom_range(0, 1) == 1;
            r.vital_event = $urandom_range(0, 1) == 1;
            r.cancel_level = $urandom_range(0, 1) == 1;
            return r;
        end
        if (seq.phase == PH_IDLE)
        begin
            r.shock_event = $urandom_range(0, 3) == 0;
            r.vital_event = $urandom_range(0, 11) == 0;
            r.warning_event = $urandom_range(0, 5) == 0;
        end
        else
        begin
            r.shock_event = $urandom_range(0, 19) == 0;
            r.vital_event = $urandom_range(0, 19) == 0;
            r.warning_event = $urandom_range(0, 9) == 0;
        end
        if (seq.phase == PH_STILL && regs.still_low <= regs.still_high
            && $urandom_range(0, 19) != 0)
            r.accel_mag = 12'($urandom_range(regs.still_low, regs.still_high));
        lim = (regs.cancel_ticks == '0) ? 8'd1 : regs.cancel_ticks;
        if (seq.phase == PH_CANCEL) r.cancel_level = $urandom_range(0, lim) == 0;
        return r;
    endfunction

    function automatic item_t rq(input logic shock, warn, vital,
                                 input logic [AccelW-1:0] accel, input logic cancel);
        item_t r;
        r.shock_event = shock;
        r.warning_event = warn;
        r.vital_event = vital;
        r.accel_mag = accel;
        r.cancel_level = cancel;
        return r;
    endfunction

    function automatic result_t rs(input logic alert, warn, sos,
                                   input outcome_t oc, input phase_t ph);
        result_t s;
        s.alert_level = alert;
        s.crash_shown = alert;
        s.send_warning = warn;
        s.send_sos = sos;
        s.outcome = oc;
        s.phase_now = ph;
        return s;
    endfunction

    function automatic plan_row_t req_row(input item_t r, input logic typed,
                                          input result_t s);
        plan_row_t row;
        row = '0;
        row.kind = ROW_REQ;
        row.req = r;
        row.typed = typed;
        row.status = s;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int          n_items;

        regs = '{settle_ticks: RST_SETTLE_TICKS, still_ticks: RST_STILL_TICKS,
                 cancel_ticks: RST_CANCEL_TICKS, still_low: RST_STILL_LOW,
                 still_high: RST_STILL_HIGH};
        seq = '{phase: PH_IDLE, tick_count: '0, still_ok: 1'b1, shock_pending: 1'b0,
                warning_pending: 1'b0, vital_pending: 1'b0};

        // reset register values
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_IDLE)));
        plan.push_back(req_row(rq(0, 1, 0, 12'd0, 0), 1, rs(0, 1, 0, OC_NONE, PH_IDLE)));
        plan.push_back(req_row(rq(0, 1, 1, 12'd0, 0), 1, rs(1, 1, 0, OC_NONE, PH_CANCEL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd4095, 1), 1,
                               rs(0, 0, 0, OC_CANCELLED, PH_IDLE)));
        plan.push_back(req_row(rq(1, 0, 1, 12'd0, 0), 1, rs(1, 0, 0, OC_NONE, PH_CANCEL)));
        plan.push_back(req_row(rq(1, 1, 0, 12'd0, 0), 1, rs(1, 0, 0, OC_NONE, PH_CANCEL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 1), 1,
                               rs(0, 0, 0, OC_CANCELLED, PH_IDLE)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 1, 0, OC_NONE, PH_IDLE)));
        // zero counts, widest band
        plan.push_back(cfg_row(REG_SETTLE_TICKS, 12'd0));
        plan.push_back(cfg_row(REG_STILL_TICKS, 12'd0));
        plan.push_back(cfg_row(REG_CANCEL_TICKS, 12'd0));
        plan.push_back(cfg_row(REG_STILL_LOW, 12'd0));
        plan.push_back(cfg_row(REG_STILL_HIGH, 12'd4095));
        plan.push_back(cfg_row(REG_UNUSED, 12'hABC));
        plan.push_back(req_row(rq(1, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_SETTLE)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_STILL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd4095, 0), 1,
                               rs(1, 0, 0, OC_NONE, PH_CANCEL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 0, 1, OC_SOS, PH_IDLE)));
        // crossed bounds
        plan.push_back(cfg_row(REG_STILL_TICKS, 12'd2));
        plan.push_back(cfg_row(REG_STILL_LOW, 12'd2048));
        plan.push_back(cfg_row(REG_STILL_HIGH, 12'd2047));
        plan.push_back(req_row(rq(1, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_SETTLE)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_STILL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd2048, 0), 1,
                               rs(0, 0, 0, OC_NONE, PH_STILL)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd2047, 0), 1,
                               rs(0, 0, 0, OC_FALSE, PH_IDLE)));
        // samples on the bounds, events inside a sequence, cancel on last tick
        plan.push_back(cfg_row(REG_SETTLE_TICKS, 12'd2));
        plan.push_back(cfg_row(REG_STILL_TICKS, 12'd3));
        plan.push_back(cfg_row(REG_CANCEL_TICKS, 12'd3));
        plan.push_back(cfg_row(REG_STILL_LOW, 12'd100));
        plan.push_back(cfg_row(REG_STILL_HIGH, 12'd200));
        plan.push_back(req_row(rq(1, 0, 0, 12'd0, 0), 1, rs(0, 0, 0, OC_NONE, PH_SETTLE)));
        plan.push_back(req_row(rq(0, 1, 0, 12'd0, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd100, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd200, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd150, 0), 0, '0));
        plan.push_back(req_row(rq(1, 0, 1, 12'd0, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 0, '0));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 1), 1,
                               rs(0, 0, 0, OC_CANCELLED, PH_IDLE)));
        plan.push_back(req_row(rq(0, 0, 0, 12'd0, 0), 1, rs(0, 1, 0, OC_NONE, PH_IDLE)));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (i == 0 || plan[i-1].kind == ROW_REQ) quiesce();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_req(plan[i].req, plan[i].typed, plan[i].status);
        end

        for (int p = 0; p < 10; p++)
        begin
            idling = (p % 3) != 2;
            case (p)
                0: set_regs(12'd255, 12'd1, 12'd2, 12'd0, 12'd4095);
                1: set_regs(12'd1, 12'd255, 12'd1, 12'd0, 12'd4095);
                2: set_regs(12'd0, 12'd1, 12'd255, 12'd4095, 12'd4095);
                default:
                begin
                    lo = $urandom_range(0, 2500);
                    if ($urandom_range(0, 5) == 0 && lo > 0) hi = $urandom_range(0, lo - 1);
                    else hi = lo + $urandom_range(0, 1500);
                    set_regs(count_draw(), count_draw(), count_draw(),
                             12'(lo), 12'(hi));
                end
            endcase
            n_items = (p < 3) ? 300 : 60;
            repeat (n_items)
            begin
                if ($urandom_range(0, 79) == 0) quiesce();
                send_req(pick_request(), 1'b0, '0);
            end
        end

        quiesce();
        $display("Covered %0d ticks and %0d register writes,", ticks_sent, cfg_writes);
        $display("  incl. zero, max and crossed-band settings; saw %0d warning pulses", n_warn);
        $display("Sequences ended %0d false alarm, %0d cancelled, %0d SOS",
                 n_false, n_cancel, n_sos);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ccs_pkg.sv
hdl/ccs_step.sv
hdl/crash_confirmation_sequencer.sv
dv/tb.sv
